// ===== rtl/ble_fr_pkg.sv =====
// shared types and constants for the ble frame reassembler
package ble_fr_pkg;

  // input beat: one received fragment byte
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       fragment_last;
  } frag_t;

  // output beat: one result for each received byte
  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [7:0]  frame_command;
    logic [15:0] frame_length;
    logic        frame_done;
    logic        frame_valid;
    logic [1:0]  error_code;
  } res_t;

  // command codes held in the configuration registers
  typedef struct packed {
    logic [7:0] code_ping;
    logic [7:0] code_keepalive;
    logic [7:0] code_message;
    logic [7:0] code_error;
  } codes_t;

  typedef enum logic [1:0] {
    PH_INIT = 2'd0,
    PH_CONT = 2'd1,
    PH_SKIP = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_SHORT    = 2'd1,
    ERR_OVERFLOW = 2'd2,
    ERR_SEQUENCE = 2'd3
  } err_t;

  // position within the three-byte initial header
  localparam logic [1:0] HDR_CMD    = 2'd0;
  localparam logic [1:0] HDR_LEN_HI = 2'd1;
  localparam logic [1:0] HDR_LEN_LO = 2'd2;
  localparam logic [1:0] HDR_BODY   = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_PING      = 2'd0;
  localparam logic [1:0] REG_KEEPALIVE = 2'd1;
  localparam logic [1:0] REG_MESSAGE   = 2'd2;
  localparam logic [1:0] REG_ERROR     = 2'd3;

  localparam logic [7:0] RST_PING      = 8'd129;
  localparam logic [7:0] RST_KEEPALIVE = 8'd130;
  localparam logic [7:0] RST_MESSAGE   = 8'd131;
  localparam logic [7:0] RST_ERROR     = 8'd191;

endpackage

// ===== rtl/ble_frame_reassembler_top.sv =====
// top level of the ble frame reassembler
//
//   channel   signals                       direction  payload
//   frag      frag_valid/frag_ready/frag    in         frag_t: rx_byte, fragment_last
//   res       res_valid/res_ready/res       out        res_t: one result per byte
//   cfg       cfg_we/cfg_index/cfg_data     in         command codes, no read-back
//
// one beat in, one beat out; a byte passes from acceptance to result through two registers
// (input register, then parse logic into the result register)
// sustained rate is one byte per cycle while res_ready stays high, set by the single parse pass on the state registers
// rst is synchronous: frame state back to awaiting an initial fragment, codes to defaults
// a stalled result holds in its register while the input register still takes a beat;
// frag_ready drops only when both stages are full and res_ready is low
module ble_frame_reassembler_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                frag_valid,
  output logic                frag_ready,
  input  ble_fr_pkg::frag_t   frag,
  output logic                res_valid,
  input  logic                res_ready,
  output ble_fr_pkg::res_t    res,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_data
);
  import ble_fr_pkg::*;

  codes_t codes;
  frag_t  held;
  logic   held_valid;
  logic   res_take;
  logic   step;
  res_t   result;

  // result register can load when empty or being drained this cycle
  assign res_take   = !res_valid || res_ready;
  // state advances only when a held beat moves into the result register
  assign step       = held_valid && res_take;
  assign frag_ready = !held_valid || res_take;

  ble_fr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .codes     (codes)
  );

  ble_fr_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (held),
    .codes  (codes),
    .result (result)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (frag_ready) begin
      held_valid <= frag_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (frag_ready && frag_valid) begin
      held <= frag;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_take) begin
      res_valid <= held_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res <= result;
    end
  end

endmodule

// ===== rtl/ble_fr_cfg.sv =====
// command code configuration registers
module ble_fr_cfg (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_data,
  output ble_fr_pkg::codes_t  codes
);
  import ble_fr_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      codes.code_ping      <= RST_PING;
      codes.code_keepalive <= RST_KEEPALIVE;
      codes.code_message   <= RST_MESSAGE;
      codes.code_error     <= RST_ERROR;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PING:      codes.code_ping      <= cfg_data;
        REG_KEEPALIVE: codes.code_keepalive <= cfg_data;
        REG_MESSAGE:   codes.code_message   <= cfg_data;
        REG_ERROR:     codes.code_error     <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/ble_fr_core.sv =====
// frame state registers and per-byte parsing logic
module ble_fr_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  ble_fr_pkg::frag_t   item,
  input  ble_fr_pkg::codes_t  codes,
  output ble_fr_pkg::res_t    result
);
  import ble_fr_pkg::*;

  phase_t      phase, phase_next;
  logic [1:0]  hdr_pos, hdr_pos_next;
  logic        frag_start;
  logic [7:0]  command, command_next;
  logic [15:0] length, length_next;
  // count never passes the declared length, so 16 bits hold it
  logic [15:0] count, count_next;
  logic [6:0]  seq, seq_next;

  logic        last;
  logic [7:0]  b;
  logic        cmd_ok;

  assign last = item.fragment_last;
  assign b    = item.rx_byte;

  assign cmd_ok = (command_next == codes.code_ping) ||
                  (command_next == codes.code_message) ||
                  (((command_next == codes.code_keepalive) ||
                    (command_next == codes.code_error)) && (length_next == 16'd1));

  always_comb begin
    logic take;
    logic frag_end;
    logic err;
    take         = 1'b0;
    frag_end     = 1'b0;
    err          = 1'b0;
    phase_next   = phase;
    hdr_pos_next = hdr_pos;
    command_next = command;
    length_next  = length;
    count_next   = count;
    seq_next     = seq;
    result       = '0;

    case (phase)
      PH_INIT: begin
        case (hdr_pos)
          HDR_CMD: begin
            command_next = b;
            length_next  = '0;
            count_next   = '0;
            seq_next     = '0;
            if (last) begin
              err               = 1'b1;
              result.error_code = ERR_SHORT;
            end else begin
              hdr_pos_next = HDR_LEN_HI;
            end
          end
          HDR_LEN_HI: begin
            length_next = {b, 8'd0};
            if (last) begin
              err               = 1'b1;
              result.error_code = ERR_SHORT;
            end else begin
              hdr_pos_next = HDR_LEN_LO;
            end
          end
          HDR_LEN_LO: begin
            length_next  = {length[15:8], b};
            hdr_pos_next = HDR_BODY;
            frag_end     = last;
          end
          default: take = 1'b1;
        endcase
      end
      PH_CONT: begin
        if (frag_start) begin
          if (b != {1'b0, seq}) begin
            err               = 1'b1;
            result.error_code = ERR_SEQUENCE;
          end else begin
            seq_next = seq + 7'd1;
            frag_end = last;
          end
        end else begin
          take = 1'b1;
        end
      end
      default: begin
        // skipping the rest of an aborted fragment
        if (last) begin
          phase_next   = PH_INIT;
          hdr_pos_next = HDR_CMD;
        end
      end
    endcase

    if (take) begin
      if (count >= length) begin
        err               = 1'b1;
        result.error_code = ERR_OVERFLOW;
      end else begin
        result.payload_valid = 1'b1;
        result.payload_byte  = b;
        count_next           = count + 16'd1;
        frag_end             = last;
      end
    end

    if (err) begin
      phase_next   = last ? PH_INIT : PH_SKIP;
      hdr_pos_next = HDR_CMD;
    end else if (frag_end) begin
      if (count_next == length_next) begin
        result.frame_done  = 1'b1;
        result.frame_valid = cmd_ok;
        phase_next         = PH_INIT;
        hdr_pos_next       = HDR_CMD;
      end else begin
        phase_next = PH_CONT;
      end
    end

    result.frame_command = command_next;
    result.frame_length  = length_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_INIT;
      hdr_pos    <= HDR_CMD;
      frag_start <= 1'b1;
      command    <= '0;
      length     <= '0;
      count      <= '0;
      seq        <= '0;
    end else if (step) begin
      phase      <= phase_next;
      hdr_pos    <= hdr_pos_next;
      frag_start <= last;
      command    <= command_next;
      length     <= length_next;
      count      <= count_next;
      seq        <= seq_next;
    end
  end

endmodule

// ===== rtl/ble_fr_checker.sv =====
// port-level checks for the ble frame reassembler, bound to the top level
module ble_fr_checker (
  input logic                clk,
  input logic                rst,
  input logic                res_valid,
  input logic                res_ready,
  input ble_fr_pkg::res_t    res
);
  import ble_fr_pkg::*;

  // a stalled result beat holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("result beat changed while stalled");

  // an erroring byte is never forwarded and never completes a frame
  a_err_quiet: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res.error_code != ERR_NONE) |-> !res.payload_valid && !res.frame_done)
    else $error("error beat carries payload or completion");

  // validity is only reported with completion
  a_valid_done: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.frame_valid |-> res.frame_done)
    else $error("frame_valid without frame_done");

  // payload byte reads zero when not forwarded
  a_byte_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.payload_valid |-> (res.payload_byte == 8'd0))
    else $error("payload byte set without payload_valid");

  // reset empties the result register
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid straight after reset");

endmodule

bind ble_frame_reassembler_top ble_fr_checker u_ble_fr_checker (.*);

// ===== dv/ble_frame_reassembler_top_tb.sv =====
// testbench for the ble frame reassembler top level
`timescale 1ns / 100ps

module ble_frame_reassembler_top_tb;
  import ble_fr_pkg::*;

  // how a generated frame is spoilt
  typedef enum {
    FAULT_NONE,
    FAULT_SHORT,
    FAULT_OVERFLOW,
    FAULT_SEQUENCE,
    FAULT_TRUNCATE
  } fault_t;

  // cycles without any beat before the run is declared hung
  localparam int QUIET_LIMIT = 1000;
  // percentage of cycles in which each side idles
  localparam int IDLE_PCT = 27;

  logic       clk;
  logic       rst = 1'b1;
  logic       frag_valid = 1'b0;
  logic       frag_ready;
  frag_t      frag = '0;
  logic       res_valid;
  logic       res_ready = 1'b0;
  res_t       res;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_PING;
  logic [7:0] cfg_data = '0;

  ble_frame_reassembler_top uut (
    .clk        (clk),
    .rst        (rst),
    .frag_valid (frag_valid),
    .frag_ready (frag_ready),
    .frag       (frag),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  frag_t pending_frags[$];   // bytes waiting to be offered to the block
  res_t  expected_res[$];    // predicted results, oldest first
  int    queued = 0;         // bytes generated so far
  int    mismatches = 0;
  int    quiet_cycles = 0;
  bit    calm = 1'b0;        // set for a stretch with no idling on either side
  res_t  got_res;

  // tracked copy of the block's registers and frame state
  codes_t      codes;
  phase_t      ph;
  logic [1:0]  hpos;
  logic        frag_start;
  logic [7:0]  cmd;
  logic [15:0] dlen;
  logic [16:0] rcount;
  logic [6:0]  seq;
  res_t        nxt;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // frame state tracking
  // ---------------------------------------------------------------------------

  // error: flag it and either restart on the next byte or skip to fragment end
  function automatic void abandon(input err_t e, input logic last);
    nxt.error_code = e;
    ph   = last ? PH_INIT : PH_SKIP;
    hpos = HDR_CMD;
  endfunction

  // fragment end without error: frame complete once the count meets the length
  function automatic void close_fragment();
    if (rcount == {1'b0, dlen}) begin
      nxt.frame_done  = 1'b1;
      // keepalive and error commands only count as valid at length one
      nxt.frame_valid = (cmd == codes.code_ping) || (cmd == codes.code_message) ||
                        (((cmd == codes.code_keepalive) || (cmd == codes.code_error)) &&
                         (dlen == 16'd1));
      ph   = PH_INIT;
      hpos = HDR_CMD;
    end else begin
      ph = PH_CONT;
    end
  endfunction

  // payload byte: forwarded unless the declared length is already reached
  function automatic logic take_byte(input logic [7:0] b, input logic last);
    if (rcount >= {1'b0, dlen}) begin
      abandon(ERR_OVERFLOW, last);
      return 1'b0;
    end
    nxt.payload_valid = 1'b1;
    nxt.payload_byte  = b;
    rcount = rcount + 17'd1;
    return 1'b1;
  endfunction

  // advances the tracked state by one byte and gives the result it causes
  function automatic res_t reassemble_byte(input frag_t f);
    nxt = '0;
    case (ph)
      PH_INIT: begin
        case (hpos)
          HDR_CMD: begin
            // command byte opens a fresh frame
            cmd    = f.rx_byte;
            dlen   = '0;
            rcount = '0;
            seq    = '0;
            if (f.fragment_last) abandon(ERR_SHORT, 1'b1);
            else hpos = HDR_LEN_HI;
          end
          HDR_LEN_HI: begin
            dlen = {f.rx_byte, 8'h00};
            if (f.fragment_last) abandon(ERR_SHORT, 1'b1);
            else hpos = HDR_LEN_LO;
          end
          HDR_LEN_LO: begin
            dlen = {dlen[15:8], f.rx_byte};
            hpos = HDR_BODY;
            if (f.fragment_last) close_fragment();
          end
          default: begin
            if (take_byte(f.rx_byte, f.fragment_last) && f.fragment_last) close_fragment();
          end
        endcase
      end
      PH_CONT: begin
        if (frag_start) begin
          // sequence byte compared on all eight bits
          if (f.rx_byte != {1'b0, seq}) begin
            abandon(ERR_SEQUENCE, f.fragment_last);
          end else begin
            seq = seq + 7'd1;
            if (f.fragment_last) close_fragment();
          end
        end else if (take_byte(f.rx_byte, f.fragment_last) && f.fragment_last) begin
          close_fragment();
        end
      end
      default: begin
        // skipping the rest of an aborted fragment
        if (f.fragment_last) begin
          ph   = PH_INIT;
          hpos = HDR_CMD;
        end
      end
    endcase
    frag_start        = f.fragment_last;
    nxt.frame_command = cmd;
    nxt.frame_length  = dlen;
    return nxt;
  endfunction

  // ---------------------------------------------------------------------------
  // driver: offers pending bytes, predicts each one as it is accepted
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      frag_valid <= 1'b0;
    end else begin
      if (frag_valid && frag_ready)
        expected_res.insert(expected_res.size(), reassemble_byte(frag));
      // a beat still waiting for ready is held as it is
      if (!frag_valid || frag_ready) begin
        if (pending_frags.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          frag       <= pending_frags.pop_front();
          frag_valid <= 1'b1;
        end else begin
          frag_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: random back-pressure, every result beat checked in order
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && res_valid && res_ready) begin
      if (expected_res.size() == 0) begin
        $error("result beat with nothing expected");
        mismatches++;
      end else begin
        got_res = expected_res.pop_front();
        check_field("payload_valid", got_res.payload_valid, res.payload_valid);
        check_field("payload_byte", got_res.payload_byte, res.payload_byte);
        check_field("frame_command", got_res.frame_command, res.frame_command);
        check_field("frame_length", got_res.frame_length, res.frame_length);
        check_field("frame_done", got_res.frame_done, res.frame_done);
        check_field("frame_valid", got_res.frame_valid, res.frame_valid);
        check_field("error_code", got_res.error_code, res.error_code);
      end
    end
    res_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  // watchdog: ends the run if no beat moves for too long
  always @(posedge clk) begin
    if (rst || (frag_valid && frag_ready) || (res_valid && res_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus generation
  // ---------------------------------------------------------------------------
  task automatic queue_byte(input logic [7:0] b, input logic last);
    frag_t f;
    f.rx_byte       = b;
    f.fragment_last = last;
    pending_frags.insert(pending_frags.size(), f);
    queued++;
  endtask

  // builds one frame cut into fragments of up to chunk payload bytes each
  task automatic queue_frame(input logic [7:0] code, input logic [15:0] len,
                             input int chunk, input fault_t fault);
    int         total;
    int         sent;
    int         room;
    int         nconts;
    int         bad_frag;
    int         idx;
    logic [6:0] cseq;
    logic [7:0] sb;
    if (fault == FAULT_SHORT) begin
      if ($urandom_range(1)) begin
        queue_byte(code, 1'b1);
      end else begin
        queue_byte(code, 1'b0);
        queue_byte(len[15:8], 1'b1);
      end
      return;
    end
    // overflow: a few bytes past the declared length
    total = int'(len) + ((fault == FAULT_OVERFLOW) ? $urandom_range(3, 1) : 0);
    room  = (chunk < total) ? chunk : total;
    queue_byte(code, 1'b0);
    queue_byte(len[15:8], 1'b0);
    queue_byte(len[7:0], room == 0);
    for (int k = 0; k < room; k++) queue_byte(8'($urandom_range(255)), k == room - 1);
    sent     = room;
    nconts   = (total - sent + chunk - 1) / chunk;
    bad_frag = (nconts > 0) ? $urandom_range((nconts - 1 < 6) ? nconts - 1 : 6) : 0;
    cseq     = '0;
    idx      = 0;
    while (sent < total) begin
      // truncation: the frame just stops, the next frame lands as a continuation
      if (fault == FAULT_TRUNCATE && idx == bad_frag) return;
      sb = {1'b0, cseq};
      if (fault == FAULT_SEQUENCE && idx == bad_frag) sb ^= 8'(1 << $urandom_range(7));
      room = (chunk < total - sent) ? chunk : total - sent;
      queue_byte(sb, 1'b0);
      for (int k = 0; k < room; k++) queue_byte(8'($urandom_range(255)), k == room - 1);
      sent += room;
      cseq = cseq + 7'd1;
      if (fault == FAULT_SEQUENCE && idx == bad_frag) return;
      idx++;
    end
  endtask

  function automatic logic [7:0] pick_command();
    case ($urandom_range(5))
      0: return codes.code_ping;
      1: return codes.code_keepalive;
      2: return codes.code_message;
      3: return codes.code_error;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [15:0] pick_length(input logic [7:0] code);
    if ((code == codes.code_keepalive || code == codes.code_error) && $urandom_range(99) < 70)
      return 16'd1;
    if ($urandom_range(99) < 4) return 16'($urandom_range(700, 200));
    return 16'($urandom_range(48));
  endfunction

  // mostly well-formed frames, some spoilt ones, a little loose noise
  task automatic random_traffic(input int n);
    int          stop_at;
    int          pick;
    int          chunk;
    logic [7:0]  code;
    logic [15:0] len;
    fault_t      fault;
    stop_at = queued + n;
    while (queued < stop_at) begin
      pick  = $urandom_range(99);
      code  = pick_command();
      len   = pick_length(code);
      chunk = $urandom_range(20, 1);
      if (pick < 78) begin
        queue_frame(code, len, chunk, FAULT_NONE);
      end else if (pick < 92) begin
        case ($urandom_range(3))
          0: fault = FAULT_SHORT;
          1: fault = FAULT_OVERFLOW;
          2: fault = FAULT_SEQUENCE;
          default: fault = FAULT_TRUNCATE;
        endcase
        // sequence and truncation faults need at least one continuation
        if ((fault == FAULT_SEQUENCE || fault == FAULT_TRUNCATE) && len <= chunk)
          len = 16'(chunk + 1 + $urandom_range(20));
        if (fault == FAULT_TRUNCATE && $urandom_range(99) < 20) len = 16'($urandom_range(65535));
        queue_frame(code, len, chunk, fault);
      end else begin
        repeat ($urandom_range(4, 1)) queue_byte(8'($urandom_range(255)), $urandom_range(99) < 30);
      end
    end
  endtask

  // sender holds off until every predicted result has come back
  task automatic drain();
    while (pending_frags.size() > 0 || frag_valid || expected_res.size() > 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_PING:      codes.code_ping      = val;
      REG_KEEPALIVE: codes.code_keepalive = val;
      REG_MESSAGE:   codes.code_message   = val;
      default:       codes.code_error     = val;
    endcase
  endtask

  task automatic load_codes(input codes_t c);
    write_reg(REG_PING, c.code_ping);
    write_reg(REG_KEEPALIVE, c.code_keepalive);
    write_reg(REG_MESSAGE, c.code_message);
    write_reg(REG_ERROR, c.code_error);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    codes      = {RST_PING, RST_KEEPALIVE, RST_MESSAGE, RST_ERROR};
    ph         = PH_INIT;
    hpos       = HDR_CMD;
    frag_start = 1'b1;
    cmd        = '0;
    dlen       = '0;
    rcount     = '0;
    seq        = '0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // ping of length zero, complete on the last header byte
    queue_byte(RST_PING, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h00, 1'b1);
    // short header ending on the command byte
    queue_byte(8'hFF, 1'b1);
    // short header ending on the length high byte
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b1);
    // keepalive at length one
    queue_byte(RST_KEEPALIVE, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h01, 1'b0);
    queue_byte(8'hFF, 1'b1);
    // error command at length two over a continuation: complete but invalid
    queue_byte(RST_ERROR, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h02, 1'b0);
    queue_byte(8'h00, 1'b1);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hAA, 1'b1);
    // largest length, then a sequence byte differing only in the top bit
    queue_byte(RST_MESSAGE, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h5A, 1'b1);
    queue_byte(8'h80, 1'b1);
    // overflow mid-fragment, remainder of the fragment skipped
    queue_byte(RST_PING, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h55, 1'b0);
    queue_byte(8'h12, 1'b1);

    random_traffic(150);
    drain();

    // code settings: extremes, all codes equal, random ones, then back to defaults
    for (int p = 0; p < 7; p++) begin
      case (p)
        0: load_codes({8'h00, 8'hFF, 8'h00, 8'hFF});
        1: load_codes({8'hFF, 8'h00, 8'hFF, 8'h00});
        2: load_codes({8'h5C, 8'h5C, 8'h5C, 8'h5C});
        6: load_codes({RST_PING, RST_KEEPALIVE, RST_MESSAGE, RST_ERROR});
        default: load_codes(32'($urandom()));
      endcase
      // one phase runs flat out and carries a frame long enough to wrap the sequence
      calm = (p == 3);
      if (p == 3) queue_frame(codes.code_message, 16'd300, 2, FAULT_NONE);
      random_traffic(150);
      drain();
      calm = 1'b0;
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
